// File: sv/atsm_pkg.sv
// shared types and constants of the affine transparent span mapper
`default_nettype none
package atsm_pkg;

  localparam int TEX_DEPTH_DEF  = 65536;
  localparam int SCREEN_DIM_DEF = 4096;
  localparam int CMD_DEPTH      = 4;
  localparam int OUT_DEPTH      = 4;

  localparam logic [1:0] ST_PIXEL    = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_INVERTED = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_FILL_INDEX      = 3'd0,
    REG_ADDR_MODE       = 3'd1,
    REG_TEX_WIDTH_LOG2  = 3'd2,
    REG_TEX_HEIGHT_LOG2 = 3'd3,
    REG_TEX_PITCH       = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_SPAN,
    CMD_STATUS,
    CMD_STEP
  } cmd_kind_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_DIV,
    FS_SAT,
    FS_MUL,
    FS_PUSH
  } front_state_t;

  typedef struct packed {
    logic       addr_mode;
    logic [3:0] wl;
    logic [3:0] hl;
    logic [8:0] pitch;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] tex_addr;
    logic        opaque;
    logic [11:0] row;
    logic [1:0]  status;
    logic [31:0] u_acc;
    logic [31:0] v_acc;
    logic [31:0] u_step;
    logic [31:0] v_step;
    logic [15:0] x_start;
    logic [15:0] x_end;
  } cmd_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic        we;
    logic        last;
    logic [1:0]  status;
  } result_t;

endpackage
`default_nettype wire

// File: sv/affine_transparent_span_mapper.sv
// top level of the affine transparent span mapper
// usage:
// - input queue port: drive in_push with an item; it is taken when in_full
//   is low. opcode 0 loads one texel opacity bit, 1 begins a span, 2 steps
//   one pixel of the active span, 3 is dropped
// - result queue port: a result waits on out_* while out_empty is low and
//   leaves on a cycle with out_pop high
// - cfg_we/cfg_index/cfg_data write one register per cycle, only while idle
// - loads and steps go straight through: one item per cycle while the front
//   is idle and the command queue is not full
// - a begin with a nonempty span holds the front through one-bit-per-cycle
//   division for du and dv, then saturation, correction multiply and the
//   queue push; empty and inverted spans go to the queue without holding it
// - the command queue lets steps of the prior span drain while the next
//   span is set up
// - when the receiver stalls the result queue fills, the back part stops,
//   then the command queue fills and in_full rises; nothing is lost
// - reset clears the span state, queues and registers to defaults; the
//   opacity store has no reset and is defined only where loaded
`default_nettype none
module affine_transparent_span_mapper #(
  parameter int TEX_DEPTH  = atsm_pkg::TEX_DEPTH_DEF,
  parameter int SCREEN_DIM = atsm_pkg::SCREEN_DIM_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_index,
  input  wire  [8:0]         cfg_data,
  input  wire                in_push,
  output logic               in_full,
  input  wire  [1:0]         in_opcode,
  input  wire  [15:0]        in_texel_addr,
  input  wire  [7:0]         in_texel_value,
  input  wire  [11:0]        in_row,
  input  wire  signed [31:0] in_x_left,
  input  wire  signed [31:0] in_x_right,
  input  wire  signed [31:0] in_u_left,
  input  wire  signed [31:0] in_u_right,
  input  wire  signed [31:0] in_v_left,
  input  wire  signed [31:0] in_v_right,
  output logic               out_empty,
  input  wire                out_pop,
  output logic [11:0]        out_pixel_x,
  output logic [11:0]        out_pixel_y,
  output logic               out_write_enable,
  output logic               out_last,
  output logic [1:0]         out_status
);

  // configuration registers; the fill color index never reaches a result
  atsm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.addr_mode <= 1'b0;
      cfg_r.wl        <= 4'd6;
      cfg_r.hl        <= 4'd6;
      cfg_r.pitch     <= 9'd64;
    end else if (cfg_we) begin
      unique case (atsm_pkg::reg_index_t'(cfg_index))
        atsm_pkg::REG_ADDR_MODE:       cfg_r.addr_mode <= cfg_data[0];
        atsm_pkg::REG_TEX_WIDTH_LOG2:  cfg_r.wl        <= cfg_data[3:0];
        atsm_pkg::REG_TEX_HEIGHT_LOG2: cfg_r.hl        <= cfg_data[3:0];
        atsm_pkg::REG_TEX_PITCH:       cfg_r.pitch     <= cfg_data;
        default: ;
      endcase
    end
  end

  // front to back command path
  logic              q_push, q_full, q_pop, q_empty;
  atsm_pkg::cmd_t    q_wdata, q_rdata;
  atsm_pkg::result_t res;

  atsm_front #(.SCREEN_DIM(SCREEN_DIM)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_texel_addr  (in_texel_addr),
    .in_texel_value (in_texel_value),
    .in_row         (in_row),
    .in_x_left      (in_x_left),
    .in_x_right     (in_x_right),
    .in_u_left      (in_u_left),
    .in_u_right     (in_u_right),
    .in_v_left      (in_v_left),
    .in_v_right     (in_v_right),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  atsm_cmd_queue #(.DEPTH(atsm_pkg::CMD_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  atsm_back #(.TEX_DEPTH(TEX_DEPTH), .SCREEN_DIM(SCREEN_DIM)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  // result fields
  assign out_pixel_x      = res.x;
  assign out_pixel_y      = res.y;
  assign out_write_enable = res.we;
  assign out_last         = res.last;
  assign out_status       = res.status;

endmodule
`default_nettype wire

// File: sv/atsm_front.sv
// front part: accepts items, sets up spans with serial division
`default_nettype none
module atsm_front #(
  parameter int SCREEN_DIM = atsm_pkg::SCREEN_DIM_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_push,
  output logic                 in_full,
  input  wire  [1:0]           in_opcode,
  input  wire  [15:0]          in_texel_addr,
  input  wire  [7:0]           in_texel_value,
  input  wire  [11:0]          in_row,
  input  wire  signed [31:0]   in_x_left,
  input  wire  signed [31:0]   in_x_right,
  input  wire  signed [31:0]   in_u_left,
  input  wire  signed [31:0]   in_u_right,
  input  wire  signed [31:0]   in_v_left,
  input  wire  signed [31:0]   in_v_right,
  input  wire                  q_full,
  output logic                 q_push,
  output atsm_pkg::cmd_t       q_data
);

  localparam int NUM_W = 49;
  localparam logic [17:0] SD18 = 18'(SCREEN_DIM);

  atsm_pkg::front_state_t state_r, state_nxt;

  logic [NUM_W-1:0] num_u_r, num_u_nxt, num_v_r, num_v_nxt;
  logic [NUM_W-1:0] quo_u_r, quo_u_nxt, quo_v_r, quo_v_nxt;
  logic [33:0]      rem_u_r, rem_u_nxt, rem_v_r, rem_v_nxt;
  logic             neg_u_r, neg_u_nxt, neg_v_r, neg_v_nxt;
  logic [32:0]      dx_r, dx_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [31:0]      ul_r, ul_nxt, vl_r, vl_nxt;
  logic [15:0]      frac_r, frac_nxt;
  logic [11:0]      row_r, row_nxt;
  logic [15:0]      xs_r, xs_nxt, xe_r, xe_nxt;
  logic [31:0]      du_r, du_nxt, dv_r, dv_nxt;
  logic [31:0]      pu_r, pu_nxt, pv_r, pv_nxt;

  logic        accept;
  logic [33:0] xl_p, xr_p;
  logic [16:0] cl, cr;
  logic [17:0] len, len_c, xe18;
  logic [32:0] d_u, d_v, a_u, a_v;
  logic [33:0] rs_u, rs_v;
  logic signed [48:0] prod_u, prod_v;

  function automatic logic [31:0] sat_q(input logic [NUM_W-1:0] q, input logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = (q > NUM_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : q[31:0];
    end else begin
      r = (q > NUM_W'(32'h8000_0000)) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atsm_pkg::FS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    num_u_r <= num_u_nxt;  num_v_r <= num_v_nxt;
    quo_u_r <= quo_u_nxt;  quo_v_r <= quo_v_nxt;
    rem_u_r <= rem_u_nxt;  rem_v_r <= rem_v_nxt;
    neg_u_r <= neg_u_nxt;  neg_v_r <= neg_v_nxt;
    dx_r    <= dx_nxt;     ul_r    <= ul_nxt;
    vl_r    <= vl_nxt;     frac_r  <= frac_nxt;
    row_r   <= row_nxt;    xs_r    <= xs_nxt;
    xe_r    <= xe_nxt;     du_r    <= du_nxt;
    dv_r    <= dv_nxt;     pu_r    <= pu_nxt;
    pv_r    <= pv_nxt;
  end

  // ceil of the 16.16 edges and span length
  assign xl_p   = {{2{in_x_left[31]}}, in_x_left} + 34'd65535;
  assign xr_p   = {{2{in_x_right[31]}}, in_x_right} + 34'd65535;
  assign cl     = xl_p[32:16];
  assign cr     = xr_p[32:16];
  assign len    = {cr[16], cr} - {cl[16], cl};
  assign len_c  = ($signed(len) > $signed(SD18)) ? SD18 : len;
  assign xe18   = {cl[16], cl} + len_c;
  assign d_u    = {in_u_right[31], in_u_right} - {in_u_left[31], in_u_left};
  assign d_v    = {in_v_right[31], in_v_right} - {in_v_left[31], in_v_left};
  assign a_u    = d_u[32] ? (~d_u + 33'd1) : d_u;
  assign a_v    = d_v[32] ? (~d_v + 33'd1) : d_v;

  // one quotient bit per cycle for both slopes
  assign rs_u   = {rem_u_r[32:0], num_u_r[NUM_W-1]};
  assign rs_v   = {rem_v_r[32:0], num_v_r[NUM_W-1]};
  assign prod_u = $signed(du_r) * $signed({1'b0, frac_r});
  assign prod_v = $signed(dv_r) * $signed({1'b0, frac_r});

  assign in_full = !(state_r == atsm_pkg::FS_IDLE && !q_full);
  assign accept  = in_push && !in_full;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    num_u_nxt = num_u_r;  num_v_nxt = num_v_r;
    quo_u_nxt = quo_u_r;  quo_v_nxt = quo_v_r;
    rem_u_nxt = rem_u_r;  rem_v_nxt = rem_v_r;
    neg_u_nxt = neg_u_r;  neg_v_nxt = neg_v_r;
    dx_nxt    = dx_r;     ul_nxt    = ul_r;
    vl_nxt    = vl_r;     frac_nxt  = frac_r;
    row_nxt   = row_r;    xs_nxt    = xs_r;
    xe_nxt    = xe_r;     du_nxt    = du_r;
    dv_nxt    = dv_r;     pu_nxt    = pu_r;
    pv_nxt    = pv_r;
    q_push    = 1'b0;
    q_data    = '0;
    q_data.kind     = atsm_pkg::CMD_STEP;
    q_data.tex_addr = in_texel_addr;
    q_data.opaque   = (in_texel_value != 8'd0);
    q_data.row      = in_row;
    unique case (state_r)
      atsm_pkg::FS_IDLE: begin
        if (accept) begin
          unique case (atsm_pkg::opcode_t'(in_opcode))
            atsm_pkg::OP_LOAD: begin
              q_push      = 1'b1;
              q_data.kind = atsm_pkg::CMD_LOAD;
            end
            atsm_pkg::OP_STEP: begin
              q_push      = 1'b1;
              q_data.kind = atsm_pkg::CMD_STEP;
            end
            atsm_pkg::OP_BEGIN: begin
              if ($signed(len) <= 18'sd0) begin
                q_push        = 1'b1;
                q_data.kind   = atsm_pkg::CMD_STATUS;
                q_data.status = (len == 18'd0) ? atsm_pkg::ST_EMPTY
                                               : atsm_pkg::ST_INVERTED;
              end else begin
                state_nxt = atsm_pkg::FS_DIV;
                cnt_nxt   = '0;
                num_u_nxt = {a_u, 16'd0};
                num_v_nxt = {a_v, 16'd0};
                neg_u_nxt = d_u[32];
                neg_v_nxt = d_v[32];
                rem_u_nxt = '0;
                rem_v_nxt = '0;
                quo_u_nxt = '0;
                quo_v_nxt = '0;
                dx_nxt    = {in_x_right[31], in_x_right} - {in_x_left[31], in_x_left};
                ul_nxt    = in_u_left;
                vl_nxt    = in_v_left;
                frac_nxt  = 16'(~in_x_left[15:0] + 16'd1);
                row_nxt   = in_row;
                xs_nxt    = cl[15:0];
                xe_nxt    = xe18[15:0];
              end
            end
            default: ;
          endcase
        end
      end
      atsm_pkg::FS_DIV: begin
        num_u_nxt = {num_u_r[NUM_W-2:0], 1'b0};
        num_v_nxt = {num_v_r[NUM_W-2:0], 1'b0};
        if (rs_u >= {1'b0, dx_r}) begin
          rem_u_nxt = rs_u - {1'b0, dx_r};
          quo_u_nxt = {quo_u_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_u_nxt = rs_u;
          quo_u_nxt = {quo_u_r[NUM_W-2:0], 1'b0};
        end
        if (rs_v >= {1'b0, dx_r}) begin
          rem_v_nxt = rs_v - {1'b0, dx_r};
          quo_v_nxt = {quo_v_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_v_nxt = rs_v;
          quo_v_nxt = {quo_v_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(NUM_W - 1)) begin
          state_nxt = atsm_pkg::FS_SAT;
        end
      end
      atsm_pkg::FS_SAT: begin
        du_nxt    = sat_q(quo_u_r, neg_u_r);
        dv_nxt    = sat_q(quo_v_r, neg_v_r);
        state_nxt = atsm_pkg::FS_MUL;
      end
      atsm_pkg::FS_MUL: begin
        // subpixel correction, floor of the product shifted down by 16
        pu_nxt    = prod_u[47:16];
        pv_nxt    = prod_v[47:16];
        state_nxt = atsm_pkg::FS_PUSH;
      end
      atsm_pkg::FS_PUSH: begin
        q_data.kind    = atsm_pkg::CMD_SPAN;
        q_data.row     = row_r;
        q_data.u_acc   = ul_r + pu_r;
        q_data.v_acc   = vl_r + pv_r;
        q_data.u_step  = du_r;
        q_data.v_step  = dv_r;
        q_data.x_start = xs_r;
        q_data.x_end   = xe_r;
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = atsm_pkg::FS_IDLE;
        end
      end
      default: state_nxt = atsm_pkg::FS_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/atsm_cmd_queue.sv
// short command queue between front and back
`default_nettype none
module atsm_cmd_queue #(
  parameter int DEPTH = atsm_pkg::CMD_DEPTH
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  atsm_pkg::cmd_t  wdata,
  output logic            full,
  input  wire             pop,
  output logic            empty,
  output atsm_pkg::cmd_t  rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  atsm_pkg::cmd_t   slot_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [PW:0]      cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// File: sv/atsm_back.sv
// back part: opacity store, span stepping and result queue
`default_nettype none
module atsm_back #(
  parameter int TEX_DEPTH  = atsm_pkg::TEX_DEPTH_DEF,
  parameter int SCREEN_DIM = atsm_pkg::SCREEN_DIM_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  atsm_pkg::cfg_t    cfg,
  input  wire               q_empty,
  input  atsm_pkg::cmd_t    q_data,
  output logic              q_pop,
  output logic              out_empty,
  input  wire               out_pop,
  output atsm_pkg::result_t out_res
);

  localparam int AW = $clog2(TEX_DEPTH);
  localparam int XW = $clog2(SCREEN_DIM);
  localparam int OD = atsm_pkg::OUT_DEPTH;
  localparam int OW = $clog2(OD);

  logic mem [TEX_DEPTH];
  logic rdata_r;

  logic [31:0]   u_acc_r, u_acc_nxt, v_acc_r, v_acc_nxt;
  logic [31:0]   u_step_r, u_step_nxt, v_step_r, v_step_nxt;
  logic [XW-1:0] x_cur_r, x_cur_nxt, x_end_r, x_end_nxt;
  logic [11:0]   row_r, row_nxt;
  logic          active_r, active_nxt;

  logic          b_valid_r, b_valid_nxt, b_pix_r, b_pix_nxt, b_last_r, b_last_nxt;
  logic [11:0]   b_x_r, b_x_nxt, b_y_r, b_y_nxt;
  logic [1:0]    b_status_r, b_status_nxt;

  atsm_pkg::result_t ofifo_r [OD];
  logic [OW-1:0] owp_r, orp_r;
  logic [OW:0]   ocnt_r;
  logic          o_push, o_pop;

  logic          fire, mem_we, mem_re, fin;
  logic [AW-1:0] waddr, raddr, fu_a, fv_a, mask, masked, pitched;
  logic [4:0]    msum;
  logic [XW-1:0] x_next;

  assign fire = !q_empty && ((ocnt_r + (OW+1)'(b_valid_r)) < (OW+1)'(OD));
  assign q_pop = fire;

  // texel address from the integer parts of u and v
  assign fu_a    = AW'($signed(u_acc_r[31:16]));
  assign fv_a    = AW'($signed(v_acc_r[31:16]));
  assign msum    = {1'b0, cfg.wl} + {1'b0, cfg.hl};
  assign mask    = ~({AW{1'b1}} << msum);
  assign masked  = ((fv_a << cfg.wl) + fu_a) & mask;
  assign pitched = AW'(fv_a * AW'(cfg.pitch)) + fu_a;
  assign raddr   = cfg.addr_mode ? pitched : masked;
  assign waddr   = AW'(q_data.tex_addr);
  assign x_next  = x_cur_r + 1'b1;
  assign fin     = (x_next == x_end_r);

  always_comb begin
    u_acc_nxt    = u_acc_r;   v_acc_nxt  = v_acc_r;
    u_step_nxt   = u_step_r;  v_step_nxt = v_step_r;
    x_cur_nxt    = x_cur_r;   x_end_nxt  = x_end_r;
    row_nxt      = row_r;     active_nxt = active_r;
    b_valid_nxt  = 1'b0;
    b_pix_nxt    = 1'b0;
    b_last_nxt   = 1'b0;
    b_x_nxt      = '0;
    b_y_nxt      = q_data.row;
    b_status_nxt = atsm_pkg::ST_PIXEL;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    if (fire) begin
      unique case (q_data.kind)
        atsm_pkg::CMD_LOAD: mem_we = 1'b1;
        atsm_pkg::CMD_SPAN: begin
          u_acc_nxt  = q_data.u_acc;
          v_acc_nxt  = q_data.v_acc;
          u_step_nxt = q_data.u_step;
          v_step_nxt = q_data.v_step;
          x_cur_nxt  = XW'(q_data.x_start);
          x_end_nxt  = XW'(q_data.x_end);
          row_nxt    = q_data.row;
          active_nxt = 1'b1;
        end
        atsm_pkg::CMD_STATUS: begin
          active_nxt   = 1'b0;
          b_valid_nxt  = 1'b1;
          b_status_nxt = q_data.status;
        end
        atsm_pkg::CMD_STEP: begin
          if (active_r) begin
            mem_re      = 1'b1;
            b_valid_nxt = 1'b1;
            b_pix_nxt   = 1'b1;
            b_last_nxt  = fin;
            b_x_nxt     = 12'(x_cur_r);
            b_y_nxt     = row_r;
            u_acc_nxt   = u_acc_r + u_step_r;
            v_acc_nxt   = v_acc_r + v_step_r;
            x_cur_nxt   = x_next;
            if (fin) begin
              active_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= q_data.opaque;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_acc_r   <= '0;  v_acc_r  <= '0;
      u_step_r  <= '0;  v_step_r <= '0;
      x_cur_r   <= '0;  x_end_r  <= '0;
      row_r     <= '0;  active_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      u_acc_r   <= u_acc_nxt;   v_acc_r  <= v_acc_nxt;
      u_step_r  <= u_step_nxt;  v_step_r <= v_step_nxt;
      x_cur_r   <= x_cur_nxt;   x_end_r  <= x_end_nxt;
      row_r     <= row_nxt;     active_r <= active_nxt;
      b_valid_r <= b_valid_nxt;
    end
    b_pix_r    <= b_pix_nxt;
    b_last_r   <= b_last_nxt;
    b_x_r      <= b_x_nxt;
    b_y_r      <= b_y_nxt;
    b_status_r <= b_status_nxt;
  end

  // result queue
  assign o_push    = b_valid_r;
  assign out_empty = (ocnt_r == '0);
  assign o_pop     = out_pop && !out_empty;
  assign out_res   = ofifo_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (o_push) begin
        owp_r <= owp_r + 1'b1;
      end
      if (o_pop) begin
        orp_r <= orp_r + 1'b1;
      end
      ocnt_r <= ocnt_r + (OW+1)'(o_push) - (OW+1)'(o_pop);
    end
    if (o_push) begin
      ofifo_r[owp_r] <= '{x: b_x_r, y: b_y_r, we: b_pix_r & rdata_r,
                          last: b_last_r, status: b_status_r};
    end
  end

  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= (OW+1)'(OD))
    else $error("result queue overfilled");

  a_room_for_stage: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (ocnt_r < (OW+1)'(OD)) || o_pop)
    else $error("pixel stage pushed into full result queue");

  a_step_needs_span: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_nxt && b_pix_nxt) |-> active_r)
    else $error("pixel issued without active span");

  a_last_ends_span: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && b_pix_nxt && b_last_nxt) |=> !active_r || $past(q_data.kind) != atsm_pkg::CMD_STEP)
    else $error("span still active after last pixel");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench of the affine transparent span mapper
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int STALL_LIMIT = 5000;  // cycles with no item moving on either side
  localparam int SETTLE      = 60;    // covers the time that a nonempty begin holds the front

  // one item as driven on the input ports
  typedef struct {
    atsm_pkg::opcode_t  op;
    logic [15:0]        addr;
    logic [7:0]         val;
    logic [11:0]        row;
    logic signed [31:0] xl, xr, ul, ur, vl, vr;
  } span_item_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic        we;
    logic        last;
    logic [1:0]  status;
  } pixel_t;

  // directed row: the item, plus a typed result where one is obvious
  typedef struct {
    span_item_t item;
    bit         typed;
    pixel_t     res;
  } row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [8:0] cfg_data;
  logic in_push, in_full;
  logic [1:0] in_opcode;
  logic [15:0] in_texel_addr;
  logic [7:0] in_texel_value;
  logic [11:0] in_row;
  logic signed [31:0] in_x_left, in_x_right, in_u_left, in_u_right, in_v_left, in_v_right;
  logic out_empty, out_pop;
  logic [11:0] out_pixel_x, out_pixel_y;
  logic out_write_enable, out_last;
  logic [1:0] out_status;

  affine_transparent_span_mapper dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_opcode(in_opcode),
    .in_texel_addr(in_texel_addr), .in_texel_value(in_texel_value), .in_row(in_row),
    .in_x_left(in_x_left), .in_x_right(in_x_right),
    .in_u_left(in_u_left), .in_u_right(in_u_right),
    .in_v_left(in_v_left), .in_v_right(in_v_right),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_write_enable(out_write_enable), .out_last(out_last), .out_status(out_status)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state: opacity store, span walker and registers
  bit          opaque [65536];
  bit          loaded [65536];
  logic [31:0] u_acc, v_acc, u_inc, v_inc;
  logic [11:0] x_cur, x_stop, span_y;
  bit          walking;
  logic [7:0]  fill_index;
  logic        addr_mode;
  logic [3:0]  wl_log2, hl_log2;
  logic [8:0]  pitch;

  pixel_t pending_pixels[$];
  int     errors;
  int     quiet_cycles;
  int     send_idle_pct, recv_idle_pct;
  int     sent;

  // texel index of the pixel the walker sits on
  function automatic logic [15:0] texel_index();
    logic [31:0] fu, fv, a;
    int sh;
    fu = {{16{u_acc[31]}}, u_acc[31:16]};
    fv = {{16{v_acc[31]}}, v_acc[31:16]};
    sh = wl_log2 + hl_log2;
    if (addr_mode == 1'b0) a = ((fv << wl_log2) + fu) & ((32'd1 << sh) - 32'd1);
    else a = fv * {23'd0, pitch} + fu;
    return a[15:0];
  endfunction

  function automatic longint clamp32(longint q);
    if (q > 64'sd2147483647) return 64'sd2147483647;
    if (q < -64'sd2147483648) return -64'sd2147483648;
    return q;
  endfunction

  // advances the predictor by one accepted item; got is set when it yields a result
  task automatic map_item(input span_item_t it, output bit got, output pixel_t r);
    longint xl, xr, cl, cr, len, dx, du, dv, frac, ul, vl;
    logic [11:0] nxt;
    logic [15:0] a;
    got = 0;
    r = '0;
    case (it.op)
      atsm_pkg::OP_LOAD: begin
        opaque[it.addr] = (it.val != 0);
        loaded[it.addr] = 1;
      end
      atsm_pkg::OP_BEGIN: begin
        xl = it.xl; xr = it.xr; ul = it.ul; vl = it.vl;
        cl = (xl + 65535) >>> 16;
        cr = (xr + 65535) >>> 16;
        len = cr - cl;
        walking = 0;
        if (len <= 0) begin
          got = 1;
          r.y = it.row;
          r.status = (len == 0) ? atsm_pkg::ST_EMPTY : atsm_pkg::ST_INVERTED;
        end else begin
          dx = xr - xl;
          du = clamp32(((longint'(it.ur) - ul) * 65536) / dx);
          dv = clamp32(((longint'(it.vr) - vl) * 65536) / dx);
          frac = cl * 65536 - xl;
          u_inc = du[31:0];
          v_inc = dv[31:0];
          u_acc = 32'(ul + ((du * frac) >>> 16));
          v_acc = 32'(vl + ((dv * frac) >>> 16));
          if (len > 4096) len = 4096;
          x_cur = cl[11:0];
          x_stop = 12'(cl + len);
          span_y = it.row;
          walking = 1;
        end
      end
      atsm_pkg::OP_STEP: begin
        if (walking) begin
          a = texel_index();
          nxt = x_cur + 12'd1;
          got = 1;
          r = '{x: x_cur, y: span_y, we: opaque[a], last: (nxt == x_stop),
                status: atsm_pkg::ST_PIXEL};
          u_acc += u_inc;
          v_acc += v_inc;
          x_cur = nxt;
          if (nxt == x_stop) walking = 0;
        end
      end
      default: ;  // unused opcode is dropped
    endcase
  endtask

  // drives one item from a falling edge until it is taken, then updates the predictor
  task automatic push_item(input span_item_t it, input bit typed = 0,
                           input pixel_t typed_res = '0);
    bit got;
    pixel_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_opcode <= it.op;
    in_texel_addr <= it.addr;
    in_texel_value <= it.val;
    in_row <= it.row;
    in_x_left <= it.xl; in_x_right <= it.xr;
    in_u_left <= it.ul; in_u_right <= it.ur;
    in_v_left <= it.vl; in_v_right <= it.vr;
    do @(posedge clk); while (in_full);
    map_item(it, got, r);
    if (got) pending_pixels.push_back(typed ? typed_res : r);
    sent++;
    @(negedge clk);
  endtask

  // a step never reads a texel that was not loaded: load it first when needed
  task automatic push_step(input span_item_t it);
    span_item_t ld;
    logic [15:0] a;
    if (walking) begin
      a = texel_index();
      if (!loaded[a]) begin
        ld = it;
        ld.op = atsm_pkg::OP_LOAD;
        ld.addr = a;
        ld.val = ($urandom_range(1) != 0) ? 8'($urandom) : 8'd0;
        push_item(ld);
      end
    end
    push_item(it);
  endtask

  task automatic write_reg(input atsm_pkg::reg_index_t idx, input logic [8:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      atsm_pkg::REG_FILL_INDEX:      fill_index = data[7:0];
      atsm_pkg::REG_ADDR_MODE:       addr_mode = data[0];
      atsm_pkg::REG_TEX_WIDTH_LOG2:  wl_log2 = data[3:0];
      atsm_pkg::REG_TEX_HEIGHT_LOG2: hl_log2 = data[3:0];
      atsm_pkg::REG_TEX_PITCH:       pitch = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // sender holds off until every expected result is out and the front has settled
  task automatic drain();
    in_push <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic span_item_t random_item(atsm_pkg::opcode_t op);
    span_item_t it;
    it.op = op;
    it.addr = 16'($urandom);
    it.val = 8'($urandom);
    it.row = 12'($urandom);
    it.xl = $urandom; it.xr = $urandom;
    it.ul = $urandom; it.ur = $urandom;
    it.vl = $urandom; it.vr = $urandom;
    return it;
  endfunction

  // mostly short well-formed spans with random texture walks, wrapped columns included
  task automatic random_span();
    span_item_t it;
    int n;
    it = random_item(atsm_pkg::OP_BEGIN);
    case ($urandom_range(9))
      0: ;  // full range edges, often inverted or long
      1: it.xr = it.xl - $signed(32'($urandom_range(0, 3 << 16)));  // inverted or empty
      default: begin
        it.xl = $signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
        it.xr = it.xl + $signed(32'($urandom_range(1, 20 << 16)));
        if ($urandom_range(2) != 0) begin
          it.ul = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
          it.ur = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
          it.vl = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
          it.vr = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        end
      end
    endcase
    push_item(it);
    n = $urandom_range(0, 22);
    repeat (n) push_step(random_item(atsm_pkg::OP_STEP));
    // a little noise between spans
    case ($urandom_range(7))
      0: push_item(random_item(atsm_pkg::OP_LOAD));
      1: push_item(random_item(atsm_pkg::OP_NONE));
      default: ;
    endcase
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_pop && !out_empty) begin
        if (pending_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected result x=%0d y=%0d we=%0d last=%0d status=%0d", $time,
                   out_pixel_x, out_pixel_y, out_write_enable, out_last, out_status);
        end else begin
          want = pending_pixels.pop_front();
          if (out_pixel_x !== want.x) begin
            errors++;
            $display("%0t: pixel_x expected %0d actual %0d", $time, want.x, out_pixel_x);
          end
          if (out_pixel_y !== want.y) begin
            errors++;
            $display("%0t: pixel_y expected %0d actual %0d", $time, want.y, out_pixel_y);
          end
          if (out_write_enable !== want.we) begin
            errors++;
            $display("%0t: write_enable expected %0d actual %0d", $time, want.we,
                     out_write_enable);
          end
          if (out_last !== want.last) begin
            errors++;
            $display("%0t: last expected %0d actual %0d", $time, want.last, out_last);
          end
          if (out_status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: pops at random per the current idle share
  always @(negedge clk) out_pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);

  row_t directed[$];
  logic [8:0] phase_cfg [4][5] = '{
    '{9'd255, 9'd0, 9'd8, 9'd8, 9'd256},
    '{9'd0,   9'd1, 9'd0, 9'd0, 9'd1},
    '{9'd17,  9'd1, 9'd3, 9'd5, 9'd256},
    '{9'd128, 9'd0, 9'd0, 9'd8, 9'd100}
  };

  initial begin
    span_item_t it;
    pixel_t r;
    errors = 0; quiet_cycles = 0; sent = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_push = 1'b0; in_opcode = '0; in_texel_addr = '0; in_texel_value = '0; in_row = '0;
    in_x_left = '0; in_x_right = '0; in_u_left = '0; in_u_right = '0;
    in_v_left = '0; in_v_right = '0; out_pop = 1'b0;
    u_acc = '0; v_acc = '0; u_inc = '0; v_inc = '0;
    x_cur = '0; x_stop = '0; span_y = '0; walking = 0;
    fill_index = 8'd0; addr_mode = 1'b0; wl_log2 = 4'd6; hl_log2 = 4'd6; pitch = 9'd64;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extreme loads, empty and inverted spans, extreme edges, stray steps
    it = random_item(atsm_pkg::OP_LOAD);
    it.addr = 16'h0000; it.val = 8'h00; directed.push_back('{it, 0, '0});
    it.addr = 16'hFFFF; it.val = 8'hFF; directed.push_back('{it, 0, '0});
    it.addr = 16'h0041; it.val = 8'h01; directed.push_back('{it, 0, '0});
    it = random_item(atsm_pkg::OP_STEP);
    directed.push_back('{it, 0, '0});  // step with no span
    it = random_item(atsm_pkg::OP_BEGIN);
    it.xl = 32'sh0001_8000; it.xr = 32'sh0001_C000; it.row = 12'hFFF;  // empty span
    r = '{x: 12'd0, y: 12'hFFF, we: 1'b0, last: 1'b0, status: atsm_pkg::ST_EMPTY};
    directed.push_back('{it, 1, r});
    it.xl = 32'sh0003_0000; it.xr = 32'sh0001_0000; it.row = 12'd0;  // inverted span
    r = '{x: 12'd0, y: 12'd0, we: 1'b0, last: 1'b0, status: atsm_pkg::ST_INVERTED};
    directed.push_back('{it, 1, r});
    it.xl = 32'sh7FFF_FFFF; it.xr = 32'sh8000_0000; it.row = 12'd7;  // inverted at extremes
    r = '{x: 12'd0, y: 12'd7, we: 1'b0, last: 1'b0, status: atsm_pkg::ST_INVERTED};
    directed.push_back('{it, 1, r});
    // widest span, cut to the screen width, with extreme texture ends
    it.xl = 32'sh8000_0001; it.xr = 32'sh7FFF_FFFF;
    it.ul = 32'sh8000_0000; it.ur = 32'sh7FFF_FFFF;
    it.vl = 32'sh7FFF_FFFF; it.vr = 32'sh8000_0000;
    directed.push_back('{it, 0, '0});
    directed.push_back('{random_item(atsm_pkg::OP_STEP), 0, '0});
    directed.push_back('{random_item(atsm_pkg::OP_STEP), 0, '0});
    directed.push_back('{random_item(atsm_pkg::OP_NONE), 0, '0});  // unused opcode
    // short span ending on the last pixel, then one stray step
    it = random_item(atsm_pkg::OP_BEGIN);
    it.xl = 32'sh0000_8000; it.xr = 32'sh0003_8000; it.row = 12'd5;
    it.ul = 32'sh0001_0000; it.ur = 32'sh0004_0000;
    it.vl = 32'sh0001_0000; it.vr = 32'sh0001_0000;
    directed.push_back('{it, 0, '0});
    repeat (4) directed.push_back('{random_item(atsm_pkg::OP_STEP), 0, '0});
    // span crossing column zero from the left
    it.xl = -32'sh0002_4000; it.xr = 32'sh0001_0000;
    directed.push_back('{it, 0, '0});
    repeat (3) directed.push_back('{random_item(atsm_pkg::OP_STEP), 0, '0});
    foreach (directed[i]) begin
      if (directed[i].item.op == atsm_pkg::OP_STEP) push_step(directed[i].item);
      else push_item(directed[i].item, directed[i].typed, directed[i].res);
    end
    drain();

    // random phases under different register settings and idle patterns
    for (int p = 0; p < 4; p++) begin
      write_reg(atsm_pkg::REG_FILL_INDEX, phase_cfg[p][0]);
      write_reg(atsm_pkg::REG_ADDR_MODE, phase_cfg[p][1]);
      write_reg(atsm_pkg::REG_TEX_WIDTH_LOG2, phase_cfg[p][2]);
      write_reg(atsm_pkg::REG_TEX_HEIGHT_LOG2, phase_cfg[p][3]);
      write_reg(atsm_pkg::REG_TEX_PITCH, phase_cfg[p][4]);
      send_idle_pct = (p == 0) ? 32 : (p == 1) ? 57 : 0;
      recv_idle_pct = (p == 0) ? 57 : (p == 1) ? 32 : 0;
      sent = 0;
      while (sent < 180) begin
        random_span();
        // pauses mid phase with nothing outstanding
        if (p == 2 && sent > 90 && sent < 100) drain();
      end
      drain();
    end

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
